[sv/aged_resource_pool_cache_core_macros.svh]
// Assertion macros for the aged resource pool cache.
// Used by the top level only; needs clk_i and rst_ni in the including scope.
`ifndef AGED_RESOURCE_POOL_CACHE_CORE_MACROS_SVH
`define AGED_RESOURCE_POOL_CACHE_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define ARPC_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

[sv/arpc_pkg.sv]
// Shared types and constants of the aged resource pool cache.
// No dependencies.
package arpc_pkg;

  localparam int unsigned SLOTS = 32;
  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned KEY_W = 64;
  localparam int unsigned TOT_W = 40;

  // Commands.
  localparam logic [1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_FLUSH   = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_HIT    = 3'd0;
  localparam logic [2:0] KIND_MISS   = 3'd1;
  localparam logic [2:0] KIND_EVICT  = 3'd2;
  localparam logic [2:0] KIND_REJECT = 3'd3;
  localparam logic [2:0] KIND_DONE   = 3'd4;

  // Eviction reasons.
  localparam logic [1:0] RSN_SKIP  = 2'd0;
  localparam logic [1:0] RSN_AGED  = 2'd1;
  localparam logic [1:0] RSN_LIMIT = 2'd2;
  localparam logic [1:0] RSN_FLUSH = 2'd3;

  // One pool entry as held in the memory.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [31:0]      handle;
    logic [31:0]      stamp;
    logic [31:0]      bytes;
  } entry_t;

endpackage

[sv/aged_resource_pool_cache_core.sv]
// Top level of the aged resource pool cache: entry memory and scan sequencer.
// Depends on arpc_pkg and aged_resource_pool_cache_core_macros.svh.
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  request  | in_valid_i, in_stall_o, command_i .. skipped_*  | in
//  result   | out_valid_o, out_stall_i, kind_o .. last_o      | out
//  config   | psel, penable, pwrite, paddr, pwdata, prdata    | in/out
//
// A release writes its entry without a scan; an acquire or flush scans the pool once and a tick
// up to twice, reading one entry memory word per cycle while the result is not stalled.
// Each scan reads entries in order and writes kept ones back compacted.
// Reset empties the pool at once; no clearing pass is needed.
// A stalled result holds the scan until it is taken.
`include "aged_resource_pool_cache_core_macros.svh"

module aged_resource_pool_cache_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [arpc_pkg::KEY_W-1:0] lookup_key_i,
  input  logic [31:0]                release_handle_i,
  input  logic [31:0]                release_bytes_i,
  input  logic                       skipped_frame_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 kind_o,
  output logic [31:0]                handle_out_o,
  output logic [1:0]                 evict_reason_o,
  output logic [arpc_pkg::TOT_W-1:0] pool_bytes_o,
  output logic [arpc_pkg::TOT_W-1:0] peak_bytes_o,
  output logic                       last_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_PROC  = 3'd2;
  localparam logic [2:0] ST_LIMIT = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // Entry memory with registered read data.
  arpc_pkg::entry_t mem [arpc_pkg::SLOTS];
  arpc_pkg::entry_t rdata_q;
  logic                       rd_en;
  logic [arpc_pkg::IDX_W-1:0] rd_addr;
  logic                       wr_en;
  logic [arpc_pkg::IDX_W-1:0] wr_addr;
  arpc_pkg::entry_t           wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Control and bookkeeping registers.
  logic [2:0]                 state_q, state_d;
  logic [arpc_pkg::CNT_W-1:0] count_q, count_d;
  logic [arpc_pkg::CNT_W-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [31:0]                frame_q, frame_d, age_q, age_d;
  logic [arpc_pkg::TOT_W-1:0] total_q, total_d, high_q, high_d;
  logic [7:0]                 max_age_q, max_age_d;
  logic                       pass2_q, pass2_d, evicted_q, evicted_d;
  logic                       found_q, found_d;
  logic [31:0]                found_h_q, found_h_d;
  logic [31:0]                ages_q, ages_d;
  logic [4:0]                 limit_q, limit_d;

  // Captured request.
  logic [1:0]                 cmd_q;
  logic [arpc_pkg::KEY_W-1:0] key_q;
  logic [31:0]                hdl_q, byt_q;
  logic                       skip_q;

  // Result register.
  logic                       ov_q, ov_d;
  logic [2:0]                 kind_q, kind_d;
  logic [31:0]                ho_q, ho_d;
  logic [1:0]                 rsn_q, rsn_d;
  logic [arpc_pkg::TOT_W-1:0] pb_q, pb_d, pk_q, pk_d;
  logic                       last_q, last_d;

  logic out_free;
  logic in_acc;
  logic cfg_wr;
  logic [31:0] diff;
  logic [31:0] bits1, bits2;
  logic [4:0]  low2;
  logic        evict;
  logic [1:0]  rsn;
  logic [arpc_pkg::TOT_W-1:0] sum_rel;
  logic [arpc_pkg::CNT_W-1:0] rp_nx;

  assign out_free = !ov_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {24'd0, max_age_q} : 32'd0;

  assign diff    = age_q - rdata_q.stamp;
  assign sum_rel = total_q + {8'd0, byt_q};
  assign rp_nx   = rp_q + 1'b1;

  // Age set reduced by its two lowest ages; lowest remaining age.
  assign bits1 = ages_q & (ages_q - 32'd1);
  assign bits2 = bits1 & (bits1 - 32'd1);
  always_comb begin
    low2 = 5'd0;
    for (int k = 31; k >= 0; k--) begin
      if (bits2[k]) begin
        low2 = 5'(k);
      end
    end
  end

  // Per-entry eviction decision during a scan.
  always_comb begin
    evict = 1'b0;
    rsn   = arpc_pkg::RSN_FLUSH;
    case (cmd_q)
      arpc_pkg::CMD_ACQUIRE: begin
        evict = !found_q && (rdata_q.key == key_q);
      end
      arpc_pkg::CMD_TICK: begin
        if (pass2_q) begin
          evict = (diff >= {27'd0, limit_q});
          rsn   = arpc_pkg::RSN_LIMIT;
        end else if (skip_q && diff != 32'd0) begin
          evict = 1'b1;
          rsn   = arpc_pkg::RSN_SKIP;
        end else if (diff >= {24'd0, max_age_q} && !evicted_q) begin
          evict = 1'b1;
          rsn   = arpc_pkg::RSN_AGED;
        end
      end
      arpc_pkg::CMD_FLUSH: begin
        evict = 1'b1;
      end
      default: begin
        evict = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rp_d      = rp_q;
    wp_d      = wp_q;
    frame_d   = frame_q;
    age_d     = age_q;
    total_d   = total_q;
    high_d    = high_q;
    max_age_d = cfg_wr && (paddr[2] == 1'b0) ? pwdata[7:0] : max_age_q;
    pass2_d   = pass2_q;
    evicted_d = evicted_q;
    found_d   = found_q;
    found_h_d = found_h_q;
    ages_d    = ages_q;
    limit_d   = limit_q;
    ov_d      = ov_q && out_stall_i;
    kind_d    = kind_q;
    ho_d      = ho_q;
    rsn_d     = rsn_q;
    pb_d      = pb_q;
    pk_d      = pk_q;
    last_d    = last_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = wp_q[arpc_pkg::IDX_W-1:0];
    wr_data   = rdata_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d   = ST_START;
          age_d     = frame_q;
          pass2_d   = 1'b0;
          evicted_d = 1'b0;
          found_d   = 1'b0;
          found_h_d = 32'd0;
          ages_d    = 32'd0;
        end
      end
      ST_START: begin
        if (cmd_q == arpc_pkg::CMD_RELEASE) begin
          if (out_free) begin
            ov_d   = 1'b1;
            rsn_d  = arpc_pkg::RSN_SKIP;
            last_d = 1'b1;
            if (count_q >= arpc_pkg::CNT_W'(arpc_pkg::SLOTS)) begin
              kind_d = arpc_pkg::KIND_REJECT;
              ho_d   = hdl_q;
              pb_d   = total_q;
              pk_d   = high_q;
            end else begin
              wr_en   = 1'b1;
              wr_addr = count_q[arpc_pkg::IDX_W-1:0];
              wr_data = '{key: key_q, handle: hdl_q, stamp: frame_q, bytes: byt_q};
              count_d = count_q + 1'b1;
              total_d = sum_rel;
              high_d  = (sum_rel > high_q) ? sum_rel : high_q;
              kind_d  = arpc_pkg::KIND_DONE;
              ho_d    = 32'd0;
              pb_d    = sum_rel;
              pk_d    = (sum_rel > high_q) ? sum_rel : high_q;
            end
            state_d = ST_IDLE;
          end
        end else begin
          if (cmd_q == arpc_pkg::CMD_TICK && !skip_q) begin
            frame_d = frame_q + 32'd1;
          end
          rp_d = '0;
          wp_d = '0;
          if (count_q == '0) begin
            state_d = ST_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = ST_PROC;
          end
        end
      end
      ST_PROC: begin
        if (out_free) begin
          if (evict) begin
            total_d   = total_q - {8'd0, rdata_q.bytes};
            evicted_d = 1'b1;
            if (cmd_q == arpc_pkg::CMD_ACQUIRE) begin
              found_d   = 1'b1;
              found_h_d = rdata_q.handle;
            end else begin
              ov_d   = 1'b1;
              kind_d = arpc_pkg::KIND_EVICT;
              ho_d   = rdata_q.handle;
              rsn_d  = rsn;
              pb_d   = total_q - {8'd0, rdata_q.bytes};
              pk_d   = high_q;
              last_d = 1'b0;
            end
          end else begin
            wr_en = 1'b1;
            wp_d  = wp_q + 1'b1;
            if (cmd_q == arpc_pkg::CMD_TICK && !pass2_q) begin
              ages_d[(diff < 32'd31) ? diff[4:0] : 5'd31] = 1'b1;
            end
          end
          rp_d = rp_nx;
          if (rp_nx < count_q) begin
            rd_en   = 1'b1;
            rd_addr = rp_nx[arpc_pkg::IDX_W-1:0];
          end else begin
            count_d = evict ? wp_q : wp_q + 1'b1;
            if (cmd_q == arpc_pkg::CMD_TICK && !pass2_q && !skip_q) begin
              state_d = ST_LIMIT;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_LIMIT: begin
        if (bits2 != 32'd0 && count_q != '0) begin
          limit_d = low2;
          pass2_d = 1'b1;
          rp_d    = '0;
          wp_d    = '0;
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = ST_PROC;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d   = 1'b1;
          rsn_d  = arpc_pkg::RSN_SKIP;
          pb_d   = total_q;
          pk_d   = high_q;
          last_d = 1'b1;
          if (cmd_q == arpc_pkg::CMD_ACQUIRE) begin
            kind_d = found_q ? arpc_pkg::KIND_HIT : arpc_pkg::KIND_MISS;
            ho_d   = found_h_q;
          end else begin
            kind_d = arpc_pkg::KIND_DONE;
            ho_d   = 32'd0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      frame_q   <= 32'd0;
      total_q   <= '0;
      high_q    <= '0;
      max_age_q <= 8'd1;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      frame_q   <= frame_d;
      total_q   <= total_d;
      high_q    <= high_d;
      max_age_q <= max_age_d;
      ov_q      <= ov_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    rp_q      <= rp_d;
    wp_q      <= wp_d;
    age_q     <= age_d;
    pass2_q   <= pass2_d;
    evicted_q <= evicted_d;
    found_q   <= found_d;
    found_h_q <= found_h_d;
    ages_q    <= ages_d;
    limit_q   <= limit_d;
    kind_q    <= kind_d;
    ho_q      <= ho_d;
    rsn_q     <= rsn_d;
    pb_q      <= pb_d;
    pk_q      <= pk_d;
    last_q    <= last_d;
    if (in_acc) begin
      cmd_q  <= command_i;
      key_q  <= lookup_key_i;
      hdl_q  <= release_handle_i;
      byt_q  <= release_bytes_i;
      skip_q <= skipped_frame_i;
    end
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = kind_q;
  assign handle_out_o   = ho_q;
  assign evict_reason_o = rsn_q;
  assign pool_bytes_o   = pb_q;
  assign peak_bytes_o   = pk_q;
  assign last_o         = last_q;

  // Checks on the sequencer.
  `ARPC_ALWAYS(a_count_max, count_q <= arpc_pkg::CNT_W'(arpc_pkg::SLOTS), "pool count overflow")
  `ARPC_ALWAYS(a_wp_behind, (state_q != ST_PROC) || (wp_q <= rp_q), "compaction overtook scan")
  `ARPC_ASSERT(a_acc_start, in_acc |=> (state_q == ST_START), "accepted request not started")

endmodule
